@@ hdl/ple_pkg.sv @@
// Package for the positional list engine: sizes, codes and transaction types.
package ple_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 9;
   localparam int POS_W    = 9;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;

   localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OP_W-1:0] OP_READ      = 3'd6;
   localparam logic [OP_W-1:0] OP_REPLACE   = 3'd7;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   localparam logic signed [DATA_W-1:0] DATA_ERR  = -32'sd1;
   localparam logic signed [DATA_W-1:0] DATA_NONE = 32'sd0;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] item;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STAT_W-1:0]        status;
      logic [CNT_W-1:0]         count;
      logic                     is_empty;
   } rsp_type;

endpackage

@@ hdl/positional_list_engine.sv @@
// Positional list engine: ordered list of signed words kept in one synchronous memory.
//
// Usage: drive req_payload and raise start; the transaction is taken at a rising
// edge with start high and busy low. Each transaction yields exactly one result,
// shown on rsp_payload for one cycle with rsp_valid high. The receiver cannot
// stall the block, so every result must be taken in the cycle it appears.
// Operations: insert first/last/at, delete first/last/at, read, replace.
// Errors (full, empty, position out of range) return data of -1 and leave
// the list unchanged.
// Errors, replace and an append at the tail are answered from the idle state;
// a read waits for the registered store read; insert and delete at a
// position first shift the entries behind it.
// The shift loop moves one entry per cycle through the single read and single
// write port of the store, until every entry behind the position has moved. busy
// stays high while the shift runs; a new transaction can be taken in the
// cycle the previous result is shown.
// Reset clears the state, the item count and the result strobe; the store contents are
// left as they are and are never used before being written.
module positional_list_engine
   import ple_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS      = 3'd1;
   localparam logic [2:0] S_INS_TAIL = 3'd2;
   localparam logic [2:0] S_INS_PUT  = 3'd3;
   localparam logic [2:0] S_DEL_CAP  = 3'd4;
   localparam logic [2:0] S_DEL_LOOP = 3'd5;
   localparam logic [2:0] S_RD_WAIT  = 3'd6;

   // Item store: one write and one registered read per cycle.
   logic signed [DATA_W-1:0] store_mem [CAPACITY];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   // Control and working registers.
   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        at_ff, at_in;
   logic [CNT_W-1:0]         src_ff, src_in;
   logic [ADDR_W-1:0]        dst_ff, dst_in;
   logic                     pend_ff, pend_in;
   logic signed [DATA_W-1:0] item_ff, item_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Decode of the incoming transaction.
   logic [CNT_W-1:0] ins_at;
   logic [CNT_W-1:0] del_at;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] count_dec;

   function automatic rsp_type make_rsp(input logic [STAT_W-1:0]        status,
                                        input logic signed [DATA_W-1:0] data,
                                        input logic [CNT_W-1:0]         cnt);
      rsp_type r;
      r.data     = data;
      r.status   = status;
      r.count    = cnt;
      r.is_empty = (cnt == '0);
      return r;
   endfunction

   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);

   always_comb begin
      case (req_payload.op)
         OP_INS_FIRST: ins_at = '0;
         OP_INS_LAST:  ins_at = count_ff;
         default:      ins_at = CNT_W'(req_payload.position);
      endcase
      case (req_payload.op)
         OP_DEL_FIRST: del_at = '0;
         OP_DEL_LAST:  del_at = count_dec;
         default:      del_at = CNT_W'(req_payload.position);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      at_in        = at_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      item_in      = item_ff;
      data_in      = data_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = src_ff[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = dst_ff;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Read the entry a delete or read will need; harmless otherwise.
            rd_addr = del_at[ADDR_W-1:0];
            if (start) begin
               case (req_payload.op) inside
                  OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_FULL, DATA_ERR, count_ff);
                     end else if (ins_at > count_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_RANGE, DATA_ERR, count_ff);
                     end else if (ins_at == count_ff) begin
                        // Append at the tail: nothing to move.
                        wr_en        = 1'b1;
                        wr_addr      = count_ff[ADDR_W-1:0];
                        wr_data      = req_payload.item;
                        count_in     = count_inc;
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_OK, DATA_NONE, count_inc);
                     end else begin
                        at_in    = ins_at[ADDR_W-1:0];
                        item_in  = req_payload.item;
                        src_in   = count_dec;
                        pend_in  = 1'b0;
                        state_in = S_INS;
                     end
                  end
                  OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_EMPTY, DATA_ERR, count_ff);
                     end else if (del_at >= count_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_RANGE, DATA_ERR, count_ff);
                     end else begin
                        src_in   = del_at + CNT_W'(1);
                        pend_in  = 1'b0;
                        state_in = S_DEL_CAP;
                     end
                  end
                  OP_READ: begin
                     if (CNT_W'(req_payload.position) >= count_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_RANGE, DATA_ERR, count_ff);
                     end else begin
                        state_in = S_RD_WAIT;
                     end
                  end
                  default: begin
                     if (CNT_W'(req_payload.position) >= count_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_RANGE, DATA_ERR, count_ff);
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = req_payload.position[ADDR_W-1:0];
                        wr_data      = req_payload.item;
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp(ST_OK, DATA_NONE, count_ff);
                     end
                  end
               endcase
            end
         end
         S_INS: begin
            // Walk down from the tail: read one entry, write the previous one up.
            rd_addr = src_ff[ADDR_W-1:0];
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            dst_in  = src_ff[ADDR_W-1:0] + ADDR_W'(1);
            pend_in = 1'b1;
            if (src_ff[ADDR_W-1:0] == at_ff) begin
               state_in = S_INS_TAIL;
            end else begin
               src_in = src_ff - CNT_W'(1);
            end
         end
         S_INS_TAIL: begin
            wr_en    = 1'b1;
            state_in = S_INS_PUT;
         end
         S_INS_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = at_ff;
            wr_data      = item_ff;
            count_in     = count_inc;
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(ST_OK, DATA_NONE, count_inc);
            state_in     = S_IDLE;
         end
         S_DEL_CAP: begin
            // Hold the removed value for the result.
            data_in  = rd_data_ff;
            state_in = S_DEL_LOOP;
         end
         S_DEL_LOOP: begin
            // Walk up to the tail: read one entry, write the previous one down.
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (src_ff == count_ff) begin
               count_in     = count_dec;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(ST_OK, data_ff, count_dec);
               state_in     = S_IDLE;
            end else begin
               rd_addr = src_ff[ADDR_W-1:0];
               dst_in  = src_ff[ADDR_W-1:0] - ADDR_W'(1);
               pend_in = 1'b1;
               src_in  = src_ff + CNT_W'(1);
            end
         end
         S_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(ST_OK, rd_data_ff, count_ff);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Store: synchronous write, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      at_ff   <= at_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      item_ff <= item_in;
      data_ff <= data_in;
      rsp_ff  <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A result only follows an accepted transaction or the end of a shift or read.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset)) |-> ($past(start && !busy) || $past(busy)))
      else $error("result strobe without a transaction");

   // The count never exceeds the store size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("item count above capacity");

   // The count moves by at most one per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((count_ff == $past(count_ff))
                         || (count_ff == $past(count_ff) + CNT_W'(1))
                         || (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("item count jumped");

   // A reported count matches the register once the result is out.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.count == count_ff))
      else $error("reported count differs from item count");

endmodule

@@ bench/list_result_checker.sv @@
// Checker for the positional list engine: tracks the list, predicts each result and compares.
module list_result_checker
   import ple_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  rsp_type rsp_payload,
   output int      mismatches,
   output int      results_awaited
);

   logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
   int unsigned              shadow_len;
   rsp_type                  pending_results [$];

   // Apply one transaction to the shadow list and return the result it should produce.
   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type     res;
      int unsigned at;
      int unsigned k;
      res.data   = DATA_NONE;
      res.status = ST_OK;
      case (r.op) inside
         OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
            at = (r.op == OP_INS_FIRST) ? 0 : (r.op == OP_INS_LAST) ? shadow_len : r.position;
            if (shadow_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (at > shadow_len) begin
               res.status = ST_RANGE;
            end else begin
               for (k = shadow_len; k > at; k--)
                  shadow_entries[k] = shadow_entries[k-1];
               shadow_entries[at] = r.item;
               shadow_len++;
            end
         end
         OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               at = (r.op == OP_DEL_FIRST) ? 0 :
                    (r.op == OP_DEL_LAST) ? shadow_len - 1 : r.position;
               if (at >= shadow_len) begin
                  res.status = ST_RANGE;
               end else begin
                  res.data = shadow_entries[at];
                  for (k = at; k + 1 < shadow_len; k++)
                     shadow_entries[k] = shadow_entries[k+1];
                  shadow_len--;
               end
            end
         end
         default: begin
            if (r.position >= shadow_len) begin
               res.status = ST_RANGE;
            end else if (r.op == OP_READ) begin
               res.data = shadow_entries[r.position];
            end else begin
               shadow_entries[r.position] = r.item;
            end
         end
      endcase
      if (res.status != ST_OK)
         res.data = DATA_ERR;
      res.count    = CNT_W'(shadow_len);
      res.is_empty = (shadow_len == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_len = 0;
         pending_results.delete();
      end else begin
         // the result of the previous transaction may show in the cycle a new one is taken
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: data %0d status %0d count %0d",
                      rsp_payload.data, rsp_payload.status, rsp_payload.count);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.data !== want.data) begin
                  $error("data: expected %0d, actual %0d", want.data, rsp_payload.data);
                  mismatches++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
                  mismatches++;
               end
               if (rsp_payload.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_payload.count);
                  mismatches++;
               end
               if (rsp_payload.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d",
                         want.is_empty, rsp_payload.is_empty);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            pending_results.push_back(apply_list_op(req_payload));
      end
      results_awaited <= pending_results.size();
   end

endmodule

@@ bench/tb_positional_list_engine.sv @@
// Testbench top for the positional list engine: stimulus, idling and the verdict.
module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int          DRAIN_WAIT  = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   int          mismatch_count;
   int          results_awaited;
   int unsigned cycle_count = 0;
   int unsigned list_len = 0;     // stimulus-side view of the list length
   int          sender_idle_pct = 0;

   positional_list_engine dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   list_result_checker result_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_payload     (rsp_payload),
      .mismatches      (mismatch_count),
      .results_awaited (results_awaited)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a hung run once the cycle limit is passed.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_positional_list_engine: FAIL");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [OP_W-1:0] op, input int unsigned pos,
                                        input logic signed [DATA_W-1:0] value);
      req_type r;
      r.op       = op;
      r.position = POS_W'(pos);
      r.item     = value;
      return r;
   endfunction

   // Mix extremes into otherwise random payload words.
   function automatic logic signed [DATA_W-1:0] pick_item();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return DATA_ERR;
         3:       return DATA_NONE;
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid positions, with the boundary and out-of-range cases sprinkled in.
   function automatic int unsigned pick_position(input bit for_insert);
      case ($urandom_range(0, 19))
         0: return $urandom_range(0, CAPACITY);
         1: return list_len;
         2: return 0;
         default: begin
            if (for_insert)
               return $urandom_range(0, list_len);
            if (list_len == 0)
               return 0;
            return $urandom_range(0, list_len - 1);
         end
      endcase
   endfunction

   // Pick a random transaction; steer inserts vs deletes to keep the list short but non-trivial.
   function automatic req_type pick_mixed();
      logic [OP_W-1:0] op;
      int              grow;
      int              sel;
      grow = (list_len < 8) ? 65 : (list_len > 48) ? 30 : 48;
      sel  = $urandom_range(0, 99);
      if (sel < grow)
         op = OP_INS_FIRST + OP_W'($urandom_range(0, 2));
      else if (sel < grow + (100 - grow) / 2)
         op = OP_DEL_FIRST + OP_W'($urandom_range(0, 2));
      else
         op = OP_READ + OP_W'($urandom_range(0, 1));
      return make_req(op, pick_position(op == OP_INS_AT), pick_item());
   endfunction

   // Present one transaction and hold it until taken. Idle the sender first, at random.
   // Leave start high on return so back-to-back transactions need no gap.
   task automatic issue(input req_type r);
      int unsigned at;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      // track the length so that later positions land mostly in range
      case (r.op) inside
         OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
            at = (r.op == OP_INS_AT) ? r.position : (r.op == OP_INS_LAST) ? list_len : 0;
            if (list_len < CAPACITY && at <= list_len)
               list_len++;
         end
         OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
            if (list_len > 0) begin
               at = (r.op == OP_DEL_AT) ? r.position : (r.op == OP_DEL_LAST) ? list_len - 1 : 0;
               if (at < list_len)
                  list_len--;
            end
         end
         default: ;
      endcase
   endtask

   // Drop start and hold until every outstanding result has come back.
   task automatic quiesce();
      start <= 1'b0;
      do @(posedge clock); while (results_awaited != 0);
   endtask

   task automatic run_mixed(input int n);
      repeat (n) issue(pick_mixed());
   endtask

   // Grow the list to capacity, mostly by appending, with some inserts, reads and replaces.
   task automatic fill_to_capacity();
      int sel;
      while (list_len < CAPACITY) begin
         sel = $urandom_range(0, 99);
         if (sel < 78)
            issue(make_req(OP_INS_LAST, 0, pick_item()));
         else if (sel < 88)
            issue(make_req(OP_INS_AT, list_len - $urandom_range(0, (list_len < 3) ? list_len : 3),
                           pick_item()));
         else if (sel < 90)
            issue(make_req(OP_INS_AT, $urandom_range(0, list_len), pick_item()));
         else if (sel < 95 && list_len > 0)
            issue(make_req(OP_READ, $urandom_range(0, list_len - 1), DATA_NONE));
         else if (list_len > 0)
            issue(make_req(OP_REPLACE, $urandom_range(0, list_len - 1), pick_item()));
      end
   endtask

   // Shrink the list back to empty, mostly from the tail.
   task automatic drain_to_empty();
      int sel;
      while (list_len > 0) begin
         sel = $urandom_range(0, 99);
         if (sel < 83)
            issue(make_req(OP_DEL_LAST, 0, DATA_NONE));
         else if (sel < 93)
            issue(make_req(OP_DEL_AT, list_len - 1 - $urandom_range(0, (list_len < 4) ?
                           list_len - 1 : 3), DATA_NONE));
         else if (sel < 95)
            issue(make_req(OP_DEL_AT, $urandom_range(0, list_len - 1), DATA_NONE));
         else
            issue(make_req(OP_READ, $urandom_range(0, list_len - 1), DATA_NONE));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: error cases on an empty list, then a short list built and torn down.
      sender_idle_pct = 16;
      issue(make_req(OP_DEL_FIRST, 0, DATA_NONE));
      issue(make_req(OP_DEL_LAST, 0, DATA_NONE));
      issue(make_req(OP_DEL_AT, 5, DATA_NONE));          // empty wins over position
      issue(make_req(OP_READ, 0, DATA_NONE));            // read on empty is out of range
      issue(make_req(OP_REPLACE, 0, 32'sd7));
      issue(make_req(OP_INS_AT, 1, 32'sd1));             // position above count
      issue(make_req(OP_INS_AT, CAPACITY, 32'sd1));
      issue(make_req(OP_INS_AT, 0, 32'sh7FFF_FFFF));     // insert at 0 acts as insert first
      issue(make_req(OP_INS_FIRST, 0, 32'sh8000_0000));
      issue(make_req(OP_INS_LAST, 0, DATA_NONE));
      issue(make_req(OP_INS_AT, 3, DATA_ERR));           // insert at count acts as append
      issue(make_req(OP_INS_AT, 2, 32'sd12345));
      issue(make_req(OP_READ, 0, DATA_NONE));
      issue(make_req(OP_READ, 4, DATA_NONE));
      issue(make_req(OP_READ, 5, DATA_NONE));
      issue(make_req(OP_REPLACE, 2, -32'sd2));
      issue(make_req(OP_READ, 2, DATA_NONE));
      issue(make_req(OP_DEL_AT, 5, DATA_NONE));
      issue(make_req(OP_DEL_AT, CAPACITY, DATA_NONE));
      issue(make_req(OP_DEL_AT, 1, DATA_NONE));
      issue(make_req(OP_DEL_LAST, 0, DATA_NONE));
      issue(make_req(OP_DEL_FIRST, 0, DATA_NONE));
      issue(make_req(OP_DEL_AT, 0, DATA_NONE));
      issue(make_req(OP_DEL_FIRST, 0, DATA_NONE));
      issue(make_req(OP_DEL_LAST, 0, DATA_NONE));

      // Random traffic with a light sender gap rate.
      run_mixed(360);

      // Hold off the sender until the block has returned everything.
      quiesce();

      // Random traffic with a heavy sender gap rate.
      sender_idle_pct = 46;
      run_mixed(360);

      // Back to back: fill to capacity, probe the full list, then drain it.
      sender_idle_pct = 0;
      fill_to_capacity();
      issue(make_req(OP_INS_FIRST, 0, pick_item()));
      issue(make_req(OP_INS_LAST, 0, pick_item()));
      issue(make_req(OP_INS_AT, 0, pick_item()));
      issue(make_req(OP_INS_AT, CAPACITY, pick_item()));  // fullness is checked first
      issue(make_req(OP_INS_AT, CAPACITY / 2, pick_item()));
      issue(make_req(OP_READ, CAPACITY - 1, DATA_NONE));
      issue(make_req(OP_READ, CAPACITY, DATA_NONE));
      issue(make_req(OP_REPLACE, 0, 32'sh7FFF_FFFF));
      issue(make_req(OP_READ, 0, DATA_NONE));
      issue(make_req(OP_DEL_AT, CAPACITY, DATA_NONE));
      issue(make_req(OP_DEL_AT, CAPACITY - 1, DATA_NONE));
      issue(make_req(OP_INS_AT, CAPACITY - 1, pick_item()));
      issue(make_req(OP_INS_AT, CAPACITY, pick_item()));
      issue(make_req(OP_DEL_FIRST, 0, DATA_NONE));         // longest delete shift
      issue(make_req(OP_INS_FIRST, 0, 32'sh8000_0000));    // longest insert shift
      issue(make_req(OP_READ, 0, DATA_NONE));
      drain_to_empty();
      issue(make_req(OP_DEL_FIRST, 0, DATA_NONE));
      issue(make_req(OP_DEL_AT, 0, DATA_NONE));
      issue(make_req(OP_READ, 0, DATA_NONE));

      // Wait out the last results, then give stray strobes a chance to show.
      quiesce();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_positional_list_engine: PASS");
      else
         $display("tb_positional_list_engine: FAIL");
      $finish;
   end

endmodule
